### sv/fuzzy_match_scorer_core_assert.svh
`ifndef FUZZY_MATCH_SCORER_CORE_ASSERT_SVH
`define FUZZY_MATCH_SCORER_CORE_ASSERT_SVH

// same-cycle implication
`define FMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fms_pkg.sv
`default_nettype none

package fms_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2
  } action_t;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam int         MATCH_WEIGHT = 10;
  localparam int         SCORE_W      = 32;

  typedef struct packed {
    logic hit;
    logic miss;
  } step_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/fuzzy_match_scorer_core.sv
// Channel  Signals                                   Transaction
// item     item_valid/item_ready, action/character/last  clear, pattern byte or text byte
// result   result_valid/result_ready, matched/score/pattern_overflow  one per last text byte
//
// One item per cycle unless stalled; a last text byte's result shows in the next cycle.
// Pattern bytes live in a one-port-write, one-port-read RAM; the next pattern byte is
// prefetched each cycle so a match can advance on consecutive text bytes.
// Synchronous reset empties the pattern; no clearing pass is needed.
// item_ready drops only while a result is held and result_ready is low.
`default_nettype none

`include "fuzzy_match_scorer_core_assert.svh"

module fuzzy_match_scorer_core #(
  parameter int PATTERN_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  character,
  input  wire logic        last,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             matched,
  output logic signed [31:0] score,
  output logic             pattern_overflow
);
  import fms_pkg::*;

  localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PW = $clog2(PATTERN_DEPTH + 1);

  logic [PW-1:0]      len;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      run;
  logic signed [31:0] run_score;
  logic               ovf;
  logic [7:0]         cur_byte;
  logic [7:0]         first_byte;
  logic               fwd_valid;
  logic [7:0]         fwd_data;

  logic               acc;
  logic               is_clr;
  logic               is_app;
  logic               is_text;
  logic               wr;
  logic               in_pattern;
  logic [PW-1:0]      pos_next;
  logic [PW-1:0]      pos_adv;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [PW:0]        raddr_full;
  logic [7:0]         rdata;
  logic [7:0]         nxt_byte;
  step_t              info;
  logic signed [31:0] score_next;

  assign item_ready = !result_valid || result_ready;
  assign acc        = item_valid && item_ready;
  assign is_clr     = acc && (action == ACT_CLEAR);
  assign is_app     = acc && (action == ACT_APPEND) && (character != SPACE_CODE);
  assign is_text    = acc && (action == ACT_TEXT);
  assign wr         = is_app && (len < PW'(PATTERN_DEPTH));
  assign in_pattern = (pos < len);
  assign waddr      = len[AW-1:0];
  assign pos_adv    = pos + PW'(1);

  always_comb begin
    pos_next = pos;
    if (is_clr || (is_text && last)) begin
      pos_next = '0;
    end else if (is_text && info.hit) begin
      pos_next = pos_adv;
    end
  end

  assign raddr_full = {1'b0, pos_next} + (PW+1)'(1);
  assign raddr      = raddr_full[AW-1:0];
  assign nxt_byte   = fwd_valid ? fwd_data : rdata;

  fms_ram #(
    .WIDTH(8),
    .DEPTH(PATTERN_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr),
    .waddr(waddr),
    .wdata(character),
    .raddr(raddr),
    .rdata(rdata)
  );

  fms_step #(
    .RW(PW)
  ) u_step (
    .cur_byte  (cur_byte),
    .character (character),
    .in_pattern(in_pattern),
    .run       (run),
    .score     (run_score),
    .info      (info),
    .score_next(score_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      pos          <= '0;
      run          <= '0;
      run_score    <= '0;
      ovf          <= 1'b0;
      fwd_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      fwd_valid <= wr && (waddr == raddr);
      pos       <= pos_next;
      if (is_text && last) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (is_clr) begin
        len       <= '0;
        run       <= '0;
        run_score <= '0;
        ovf       <= 1'b0;
      end else if (is_app) begin
        if (wr) begin
          len <= len + PW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end else if (is_text) begin
        if (last) begin
          run       <= '0;
          run_score <= '0;
        end else begin
          run_score <= score_next;
          if (info.hit) begin
            run <= run + PW'(1);
          end else if (info.miss) begin
            run <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= character;
    if (wr && (len == '0)) begin
      first_byte <= character;
    end
    if (wr && (len == pos_next)) begin
      cur_byte <= character;
    end else if (is_text && last) begin
      cur_byte <= first_byte;
    end else if (is_text && info.hit) begin
      cur_byte <= nxt_byte;
    end
    if (is_text && last) begin
      matched          <= ((info.hit ? pos_adv : pos) >= len) && !ovf;
      score            <= score_next;
      pattern_overflow <= ovf;
    end
  end

  `FMS_ASSERT_IMP(a_pos_in_range, clk, rst, 1'b1, pos <= len, "pattern position past length")
  `FMS_ASSERT_IMP(a_len_in_range, clk, rst, 1'b1, len <= PW'(PATTERN_DEPTH), "length past depth")
  `FMS_ASSERT_IMP(a_no_accept_on_stall, clk, rst, item_valid && item_ready,
                  !(result_valid && !result_ready), "item accepted while result stalled")
  `FMS_ASSERT_NXT(a_result_follows, clk, rst, is_text && last, result_valid,
                  "last text byte gave no result")
  `FMS_ASSERT_IMP(a_overflow_no_match, clk, rst, result_valid && pattern_overflow, !matched,
                  "match reported on overflowed pattern")

endmodule

`default_nettype wire

### sv/fms_ram.sv
`default_nettype none

module fms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/fms_step.sv
`default_nettype none

module fms_step #(
  parameter int RW = 6
) (
  input  wire logic [7:0]                  cur_byte,
  input  wire logic [7:0]                  character,
  input  wire logic                        in_pattern,
  input  wire logic [RW-1:0]               run,
  input  wire logic signed [fms_pkg::SCORE_W-1:0] score,
  output fms_pkg::step_t                   info,
  output logic signed [fms_pkg::SCORE_W-1:0] score_next
);
  import fms_pkg::*;

  logic              not_space;
  logic              case_diff;
  logic signed [33:0] delta;
  logic signed [33:0] total;

  assign not_space = (character != SPACE_CODE);
  assign case_diff = (character != cur_byte);
  assign info.hit  = in_pattern && not_space && (fold_lower(character) == fold_lower(cur_byte));
  assign info.miss = in_pattern && not_space && !info.hit;

  always_comb begin
    delta = '0;
    if (!in_pattern) begin
      delta = -34'sd1;
    end else if (info.hit) begin
      delta = $signed(34'(run) * 34'(MATCH_WEIGHT)) - $signed(34'(case_diff));
    end else if (info.miss) begin
      delta = -$signed(34'(MATCH_WEIGHT));
    end
    total = 34'(score) + delta;
    if (total > 34'sd2147483647) begin
      score_next = 32'sh7FFFFFFF;
    end else if (total < -34'sd2147483648) begin
      score_next = 32'sh80000000;
    end else begin
      score_next = total[31:0];
    end
  end

endmodule

`default_nettype wire
